/* rtl/lspb_pkg.sv */
// Shared types, constants and the display bin threshold function of the spectrum binner.
`default_nettype none
package lspb_pkg;

    localparam int NUM_BINS_DEF = 32;
    localparam int LEVEL_W = 17;
    localparam int STEP_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;
    localparam int OUT_IDX_W = 6;
    localparam int BIG_W = 1040;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 1'b1;

    localparam logic [LEVEL_W-1:0] DECAY_RST = 17'd65536;
    localparam logic [STEP_W-1:0] STEP_RST = 16'd374;
    localparam logic [LEVEL_W-1:0] UNITY_Q16 = 17'd65536;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 17'h1FFFF;
    localparam logic signed [16:0] DB_OFFSET = 17'sd24576;
    localparam logic [18:0] RECIP3 = 19'd349526;

    typedef struct packed {
        logic               frame_start;
        logic               frame_end;
        logic signed [15:0] power_db;
        logic [15:0]        freq_hz;
    } t_in_item;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] bin_index;
        logic [LEVEL_W-1:0]   shown_level;
        logic                 last_bin;
    } t_out_item;

    function automatic logic [BIG_W-1:0] f_pow(logic [16:0] base, int n);
        logic [BIG_W-1:0] acc;
        acc = BIG_W'(1);
        for (int i = 0; i < n; i++) begin
            acc = acc * BIG_W'(base);
        end
        return acc;
    endfunction

    // Smallest frequency f with (f/20)^n >= 1000^k, found by binary search.
    function automatic logic [16:0] f_thresh(int n, int k);
        logic [BIG_W-1:0] target;
        int lo;
        int hi;
        int mid;
        target = f_pow(17'd20, n);
        for (int j = 0; j < k; j++) begin
            target = target * BIG_W'(1000);
        end
        lo = 0;
        hi = 65536;
        for (int it = 0; it < 18; it++) begin
            if (lo < hi) begin
                mid = (lo + hi) / 2;
                if (f_pow(17'(mid), n) >= target) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
        end
        return 17'(lo);
    endfunction

endpackage
`default_nettype wire

/* rtl/log_spectrum_peak_hold_binner.sv */
// Log-frequency spectrum peak-hold binner: sequencer, memories and one shared multiplier.
// An item without marks passes ST_LVL and ST_UPD before the next item can be accepted; a dropped item skips ST_UPD.
// A frame start first walks every bin through ST_DEC_RD and ST_DEC_WR to decay the peak memory.
// A frame end then reads out every bin through ST_RPT_RD and ST_RPT_WR; an output stall holds
// the readout in ST_RPT_WR until the output is free.
// Synchronous reset clears control state and the valid bits at once; no clearing pass is needed.
`default_nettype none
module log_spectrum_peak_hold_binner #(
    parameter int NUM_BINS = lspb_pkg::NUM_BINS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire lspb_pkg::t_in_item                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output lspb_pkg::t_out_item                     o_out_data,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [lspb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lspb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import lspb_pkg::*;

    localparam int IW = $clog2(NUM_BINS);
    localparam logic [IW-1:0] IDX_LAST = IW'(NUM_BINS - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DEC_RD = 3'd1;
    localparam logic [2:0] ST_DEC_WR = 3'd2;
    localparam logic [2:0] ST_LVL    = 3'd3;
    localparam logic [2:0] ST_UPD    = 3'd4;
    localparam logic [2:0] ST_RPT_RD = 3'd5;
    localparam logic [2:0] ST_RPT_WR = 3'd6;

    logic [2:0]           r_state, n_state;
    logic [IW-1:0]        r_idx, n_idx;
    logic [IW-1:0]        r_bin, n_bin;
    logic [LEVEL_W-1:0]   r_lvl, n_lvl;
    t_in_item             r_item;
    logic [LEVEL_W-1:0]   r_decay;
    logic [STEP_W-1:0]    r_step;

    logic [LEVEL_W-1:0]   r_peak_mem [NUM_BINS];
    logic [LEVEL_W-1:0]   r_shown_mem [NUM_BINS];
    logic [NUM_BINS-1:0]  r_peak_vld;
    logic [NUM_BINS-1:0]  r_shown_vld;
    logic [LEVEL_W-1:0]   r_peak_rd;
    logic                 r_peak_rdv;
    logic [LEVEL_W-1:0]   r_shown_rd;

    logic                 r_out_vld;
    t_out_item            r_out;

    logic                 in_acc;
    logic                 out_free;
    logic                 out_load;
    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic                 pk_we;
    logic [IW-1:0]        pk_waddr;
    logic [LEVEL_W-1:0]   pk_wdata;
    logic                 sh_we;
    logic [LEVEL_W-1:0]   shown_new;

    logic [LEVEL_W-1:0]   peak_q;
    logic [LEVEL_W-1:0]   df_eff;
    logic [18:0]          mul_a, mul_b;
    logic [37:0]          mul_p;
    logic [LEVEL_W-1:0]   dec_v;
    logic [17:0]          lvl_raw;
    logic [LEVEL_W-1:0]   lvl_sat;
    logic signed [16:0]   lvl_a;
    logic                 lvl_ok;
    logic [IW:0]          map_bin;
    logic [LEVEL_W-1:0]   diff;

    lspb_map #(
        .NUM_BINS (NUM_BINS)
    ) u_map (
        .i_freq (r_item.freq_hz),
        .o_bin  (map_bin)
    );

    assign in_acc = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free = !r_out_vld || !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data = r_out;

    assign peak_q = r_peak_rdv ? r_peak_rd : '0;
    assign df_eff = (r_decay > UNITY_Q16) ? UNITY_Q16 : r_decay;

    assign lvl_a = $signed({r_item.power_db[15], r_item.power_db}) + DB_OFFSET;
    assign lvl_ok = !lvl_a[16] && (lvl_a != '0);

    // The single multiplier: decay scaling, or level = floor(8 * a / 3) by reciprocal.
    always_comb begin
        if (r_state == ST_DEC_WR) begin
            mul_a = {2'b00, peak_q};
            mul_b = {2'b00, df_eff};
        end else begin
            mul_a = {lvl_a[15:0], 3'b000};
            mul_b = RECIP3;
        end
    end
    assign mul_p = mul_a * mul_b;
    assign dec_v = mul_p[32:16];
    assign lvl_raw = mul_p[37:20];
    assign lvl_sat = lvl_raw[17] ? LEVEL_MAX : lvl_raw[16:0];

    assign diff = (r_shown_rd > peak_q) ? (r_shown_rd - peak_q) : (peak_q - r_shown_rd);
    assign shown_new = (!r_shown_vld[r_idx] || (diff >= {1'b0, r_step})) ? peak_q : r_shown_rd;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_bin    = r_bin;
        n_lvl    = r_lvl;
        rd_en    = 1'b0;
        rd_addr  = r_idx;
        pk_we    = 1'b0;
        pk_waddr = r_idx;
        pk_wdata = (dec_v < {1'b0, r_step}) ? '0 : dec_v;
        sh_we    = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx = '0;
                    n_state = i_in_data.frame_start ? ST_DEC_RD : ST_LVL;
                end
            end
            ST_DEC_RD: begin
                rd_en = 1'b1;
                n_state = ST_DEC_WR;
            end
            ST_DEC_WR: begin
                pk_we = 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_idx = '0;
                    n_state = ST_LVL;
                end else begin
                    n_idx = r_idx + IW'(1);
                    n_state = ST_DEC_RD;
                end
            end
            ST_LVL: begin
                n_lvl = lvl_sat;
                n_idx = '0;
                if (lvl_ok && (map_bin < (IW + 1)'(NUM_BINS))) begin
                    n_bin = (map_bin < (IW + 1)'(2)) ? IW'(1) : map_bin[IW-1:0];
                    rd_en = 1'b1;
                    rd_addr = n_bin;
                    n_state = ST_UPD;
                end else begin
                    n_state = r_item.frame_end ? ST_RPT_RD : ST_IDLE;
                end
            end
            ST_UPD: begin
                pk_waddr = r_bin;
                pk_wdata = r_lvl;
                pk_we = (r_lvl > peak_q);
                n_state = r_item.frame_end ? ST_RPT_RD : ST_IDLE;
            end
            ST_RPT_RD: begin
                rd_en = 1'b1;
                n_state = ST_RPT_WR;
            end
            ST_RPT_WR: begin
                if (out_free) begin
                    sh_we = 1'b1;
                    out_load = 1'b1;
                    if (r_idx == IDX_LAST) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                        n_state = ST_RPT_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_decay     <= DECAY_RST;
            r_step      <= STEP_RST;
            r_peak_vld  <= '0;
            r_shown_vld <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DECAY: r_decay <= i_cfg_data;
                    CFG_STEP:  r_step <= i_cfg_data[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (pk_we) begin
                r_peak_vld[pk_waddr] <= 1'b1;
            end
            if (sh_we) begin
                r_shown_vld[r_idx] <= 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_lvl <= n_lvl;
        if (in_acc) begin
            r_item <= i_in_data;
        end
        if (out_load) begin
            r_out.bin_index   <= OUT_IDX_W'(r_idx);
            r_out.shown_level <= shown_new;
            r_out.last_bin    <= (r_idx == IDX_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pk_we) begin
            r_peak_mem[pk_waddr] <= pk_wdata;
        end
        if (rd_en) begin
            r_peak_rd  <= r_peak_mem[rd_addr];
            r_peak_rdv <= r_peak_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            r_shown_mem[r_idx] <= shown_new;
        end
        if (rd_en) begin
            r_shown_rd <= r_shown_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.last_bin) |-> (o_out_data.bin_index == OUT_IDX_W'(IDX_LAST)))
        else $error("last display bin carries the wrong index");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != ST_IDLE))
        else $error("accepted item did not start processing");

    a_readout_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last_bin)
            |=> (r_state == ST_RPT_RD || r_state == ST_RPT_WR || o_out_data.last_bin))
        else $error("readout stopped before the last display bin");

    a_all_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_idx == IDX_LAST) |=> (&r_shown_vld))
        else $error("display bins left unshown after a full readout");
`endif

endmodule
`default_nettype wire

/* rtl/lspb_map.sv */
// Frequency to display bin mapping against build-time logarithmic thresholds.
`default_nettype none
module lspb_map #(
    parameter int NUM_BINS = lspb_pkg::NUM_BINS_DEF
) (
    input  wire logic [15:0]                    i_freq,
    output logic [$clog2(NUM_BINS):0]           o_bin
);
    import lspb_pkg::*;

    localparam int IW = $clog2(NUM_BINS);

    logic [NUM_BINS-1:0] hit;

    for (genvar k = 1; k <= NUM_BINS; k++) begin : g_th
        localparam logic [16:0] THRESH = f_thresh(NUM_BINS, k);
        assign hit[k-1] = ({1'b0, i_freq} >= THRESH);
    end

    always_comb begin
        o_bin = '0;
        for (int k = 0; k < NUM_BINS; k++) begin
            if (hit[k]) begin
                o_bin = (IW + 1)'(k + 1);
            end
        end
    end

endmodule
`default_nettype wire
